>>> hdl/mrtu_pkg.sv
`timescale 1ns / 1ps

package mrtu_pkg;

    localparam int DATA_BYTES = 4;
    localparam int COUNT_W    = $clog2(DATA_BYTES + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] BROADCAST_ADDR      = 8'h00;
    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] EXCEPTION_FLAG      = 8'h80;

    localparam logic [7:0] FC_READ_COILS     = 8'h01;
    localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
    localparam logic [7:0] FC_WRITE_REGISTER = 8'h06;

    localparam logic [1:0] EX_NONE                 = 2'd0;
    localparam logic [1:0] EX_ILLEGAL_FUNCTION     = 2'd1;
    localparam logic [1:0] EX_ILLEGAL_DATA_ADDRESS = 2'd2;

    localparam logic ITEM_BYTE    = 1'b0;
    localparam logic ITEM_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        PH_ADDR = 3'd0,
        PH_FUNC = 3'd1,
        PH_DATA = 3'd2,
        PH_CRC1 = 3'd3,
        PH_CRC2 = 3'd4,
        PH_WAIT = 3'd5
    } phase_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        crc_good;
        logic        respond;
        logic [7:0]  frame_address;
        logic [7:0]  function_code;
        logic [31:0] request_data;
        logic [7:0]  response_code;
        logic [1:0]  exception_code;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic code_handled(input logic [7:0] c);
        return (c == FC_READ_COILS) || (c == FC_READ_HOLDING) ||
               (c == FC_WRITE_COIL) || (c == FC_WRITE_REGISTER);
    endfunction

endpackage

>>> hdl/mrtu_rx_fsm.sv
`timescale 1ns / 1ps

module mrtu_rx_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  mrtu_pkg::item_t  item,
    input  logic [7:0]       slave_address,
    output logic             emit,
    output mrtu_pkg::result_t result
);

    mrtu_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                    held_address_reg, held_address_next;
    logic [7:0]                    held_function_reg, held_function_next;
    logic [31:0]                   held_data_reg, held_data_next;
    logic [mrtu_pkg::COUNT_W-1:0]  data_count_reg, data_count_next;
    logic [15:0]                   running_crc_reg, running_crc_next;
    logic [7:0]                    first_crc_byte_reg, first_crc_byte_next;
    logic [15:0]                   crc_fed;
    logic                          crc_good;
    logic                          respond;

    assign crc_fed = mrtu_pkg::crc_feed(
        (phase_reg == mrtu_pkg::PH_ADDR) ? mrtu_pkg::CRC_INIT : running_crc_reg, item.rx_byte);

    always_comb
    begin
        phase_next          = phase_reg;
        held_address_next   = held_address_reg;
        held_function_next  = held_function_reg;
        held_data_next      = held_data_reg;
        data_count_next     = data_count_reg;
        running_crc_next    = running_crc_reg;
        first_crc_byte_next = first_crc_byte_reg;
        if (item.func == mrtu_pkg::ITEM_TIMEOUT)
        begin
            phase_next       = mrtu_pkg::PH_ADDR;
            data_count_next  = '0;
            running_crc_next = mrtu_pkg::CRC_INIT;
        end
        else
        begin
            unique case (phase_reg)
                mrtu_pkg::PH_ADDR:
                begin
                    held_address_next = item.rx_byte;
                    held_data_next    = '0;
                    data_count_next   = '0;
                    running_crc_next  = crc_fed;
                    phase_next        = (item.rx_byte == slave_address ||
                                         item.rx_byte == mrtu_pkg::BROADCAST_ADDR)
                                        ? mrtu_pkg::PH_FUNC : mrtu_pkg::PH_WAIT;
                end
                mrtu_pkg::PH_FUNC:
                begin
                    held_function_next = item.rx_byte;
                    running_crc_next   = crc_fed;
                    phase_next         = mrtu_pkg::PH_DATA;
                end
                mrtu_pkg::PH_DATA:
                begin
                    if (!mrtu_pkg::code_handled(held_function_reg))
                    begin
                        phase_next = mrtu_pkg::PH_WAIT;
                    end
                    else
                    begin
                        held_data_next   = {held_data_reg[23:0], item.rx_byte};
                        running_crc_next = crc_fed;
                        data_count_next  = data_count_reg + 1'b1;
                        if (data_count_next >= mrtu_pkg::COUNT_W'(mrtu_pkg::DATA_BYTES))
                        begin
                            phase_next = mrtu_pkg::PH_CRC1;
                        end
                    end
                end
                mrtu_pkg::PH_CRC1:
                begin
                    first_crc_byte_next = item.rx_byte;
                    phase_next          = mrtu_pkg::PH_CRC2;
                end
                mrtu_pkg::PH_CRC2:
                begin
                    phase_next = mrtu_pkg::PH_WAIT;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        emit     = (item.func == mrtu_pkg::ITEM_BYTE) && (phase_reg == mrtu_pkg::PH_CRC2);
        crc_good = ({item.rx_byte, first_crc_byte_reg} == running_crc_reg);
        respond  = crc_good && (held_address_reg != mrtu_pkg::BROADCAST_ADDR);
        result.crc_good       = crc_good;
        result.respond        = respond;
        result.frame_address  = held_address_reg;
        result.function_code  = held_function_reg;
        result.request_data   = held_data_reg;
        result.response_code  = respond ? (held_function_reg | mrtu_pkg::EXCEPTION_FLAG) : 8'h00;
        result.exception_code = !respond ? mrtu_pkg::EX_NONE :
                                (held_function_reg == mrtu_pkg::FC_WRITE_REGISTER)
                                ? mrtu_pkg::EX_ILLEGAL_FUNCTION
                                : mrtu_pkg::EX_ILLEGAL_DATA_ADDRESS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= mrtu_pkg::PH_ADDR;
            held_address_reg   <= '0;
            held_function_reg  <= '0;
            held_data_reg      <= '0;
            data_count_reg     <= '0;
            running_crc_reg    <= mrtu_pkg::CRC_INIT;
            first_crc_byte_reg <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            held_address_reg   <= held_address_next;
            held_function_reg  <= held_function_next;
            held_data_reg      <= held_data_next;
            data_count_reg     <= data_count_next;
            running_crc_reg    <= running_crc_next;
            first_crc_byte_reg <= first_crc_byte_next;
        end
    end

endmodule

>>> hdl/mrtu_out_reg.sv
`timescale 1ns / 1ps

module mrtu_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mrtu_pkg::result_t load_data,
    output logic              free,
    output logic              result_valid,
    input  logic              result_ready,
    output mrtu_pkg::result_t result
);

    logic              valid_reg, valid_next;
    mrtu_pkg::result_t data_reg;

    assign free         = !valid_reg || result_ready;
    assign valid_next   = load || (valid_reg && !result_ready);
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> hdl/modbus_rtu_slave_request_receiver.sv
`timescale 1ns / 1ps

// Modbus RTU slave request receiver.
// item channel (item_valid/item_ready/item): one received byte or one
// inter-frame timeout tick per transfer; a tick returns the receiver to the
// address phase.
// result channel (result_valid/result_ready/result): one transfer per frame to
// this slave or broadcast with a handled function code, raised on the second
// CRC byte, carrying the CRC check, the frame fields and the response decision.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes the own slave address;
// always ready, write only while no frame is in flight.
// A result shows once the last CRC byte has passed the input register, then the
// result register.
// Throughput: one item per cycle but for the stall below; the per-byte CRC update
// and phase step sit between the input register and the state registers.
// When result_ready is low a waiting result holds, bytes that cause no result
// keep flowing, and only the next second-CRC byte stalls in the input register.
// Reset: address phase, CRC 0xFFFF, slave address 1, both channels empty.
module modbus_rtu_slave_request_receiver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mrtu_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output mrtu_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    logic              item_valid_reg, item_valid_next;
    mrtu_pkg::item_t   item_reg;
    logic [7:0]        slave_address_reg;
    logic              emit;
    logic              out_free;
    logic              advance;
    mrtu_pkg::result_t fsm_result;

    assign cfg_ready       = 1'b1;
    assign advance         = item_valid_reg && (!emit || out_free);
    assign item_ready      = !item_valid_reg || advance;
    assign item_valid_next = (item_valid && item_ready) || (item_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            slave_address_reg <= mrtu_pkg::SLAVE_ADDRESS_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                slave_address_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    mrtu_rx_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (item_reg),
        .slave_address (slave_address_reg),
        .emit          (emit),
        .result        (fsm_result)
    );

    mrtu_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && emit),
        .load_data    (fsm_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> hdl/mrtu_checker.sv
`timescale 1ns / 1ps

module mrtu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input mrtu_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_respond_rule: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.respond |->
        result.crc_good && (result.frame_address != mrtu_pkg::BROADCAST_ADDR))
        else $error("respond without good CRC or on broadcast");

    a_response_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.respond |->
        (result.response_code == (result.function_code | mrtu_pkg::EXCEPTION_FLAG)) &&
        (result.exception_code != mrtu_pkg::EX_NONE))
        else $error("bad exception response");

    a_silent_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.respond |->
        (result.response_code == 8'h00) && (result.exception_code == mrtu_pkg::EX_NONE))
        else $error("response fields set without respond");

endmodule

bind modbus_rtu_slave_request_receiver mrtu_checker u_mrtu_checker (.*);

>>> tb/sv/modbus_rtu_slave_request_receiver_checker.sv
`timescale 1ns / 1ps

module modbus_rtu_slave_request_receiver_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  mrtu_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  mrtu_pkg::result_t result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output int                failures,
    output int                pending,
    output int                reports_checked
);

    mrtu_pkg::phase_t  rx_phase;
    logic [7:0]        own_addr;
    logic [7:0]        addr_hold;
    logic [7:0]        func_hold;
    logic [7:0]        crc_lo;
    logic [31:0]       data_hold;
    logic [2:0]        data_seen;
    logic [15:0]       crc_acc;
    mrtu_pkg::result_t report_q[$];

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            fb = r[0] ^ octet[k];
            r  = {1'b0, r[15:1]};
            if (fb)
            begin
                r = r ^ mrtu_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic code_served(input logic [7:0] code);
        case (code)
            mrtu_pkg::FC_READ_COILS, mrtu_pkg::FC_READ_HOLDING,
            mrtu_pkg::FC_WRITE_COIL, mrtu_pkg::FC_WRITE_REGISTER: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int field_miss(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mrtu_pkg::result_t want;
        logic              good;
        logic              reply;
        if (!rst_n)
        begin
            rx_phase        = mrtu_pkg::PH_ADDR;
            own_addr        = mrtu_pkg::SLAVE_ADDRESS_RESET;
            addr_hold       = '0;
            func_hold       = '0;
            crc_lo          = '0;
            data_hold       = '0;
            data_seen       = '0;
            crc_acc         = mrtu_pkg::CRC_INIT;
            failures        = 0;
            reports_checked = 0;
            report_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                own_addr = cfg_data;
            end

            if (result_valid && result_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none, actual %h", $time, result);
                    failures++;
                end
                else
                begin
                    want = report_q.pop_front();
                    failures += field_miss("crc_good", want.crc_good, result.crc_good);
                    failures += field_miss("respond", want.respond, result.respond);
                    failures += field_miss("frame_address", want.frame_address,
                                           result.frame_address);
                    failures += field_miss("function_code", want.function_code,
                                           result.function_code);
                    failures += field_miss("request_data", want.request_data,
                                           result.request_data);
                    failures += field_miss("response_code", want.response_code,
                                           result.response_code);
                    failures += field_miss("exception_code", want.exception_code,
                                           result.exception_code);
                    reports_checked++;
                end
            end

            if (item_valid && item_ready)
            begin
                if (item.func == mrtu_pkg::ITEM_TIMEOUT)
                begin
                    rx_phase  = mrtu_pkg::PH_ADDR;
                    data_seen = '0;
                    crc_acc   = mrtu_pkg::CRC_INIT;
                end
                else
                begin
                    case (rx_phase)
                        mrtu_pkg::PH_ADDR:
                        begin
                            addr_hold = item.rx_byte;
                            data_hold = '0;
                            data_seen = '0;
                            crc_acc   = crc16_byte(mrtu_pkg::CRC_INIT, item.rx_byte);
                            rx_phase  = (item.rx_byte == own_addr ||
                                         item.rx_byte == mrtu_pkg::BROADCAST_ADDR)
                                        ? mrtu_pkg::PH_FUNC : mrtu_pkg::PH_WAIT;
                        end
                        mrtu_pkg::PH_FUNC:
                        begin
                            func_hold = item.rx_byte;
                            crc_acc   = crc16_byte(crc_acc, item.rx_byte);
                            rx_phase  = mrtu_pkg::PH_DATA;
                        end
                        mrtu_pkg::PH_DATA:
                        begin
                            if (!code_served(func_hold))
                            begin
                                rx_phase = mrtu_pkg::PH_WAIT;
                            end
                            else
                            begin
                                data_hold = {data_hold[23:0], item.rx_byte};
                                crc_acc   = crc16_byte(crc_acc, item.rx_byte);
                                data_seen = data_seen + 3'd1;
                                if (data_seen >= mrtu_pkg::DATA_BYTES)
                                begin
                                    rx_phase = mrtu_pkg::PH_CRC1;
                                end
                            end
                        end
                        mrtu_pkg::PH_CRC1:
                        begin
                            crc_lo   = item.rx_byte;
                            rx_phase = mrtu_pkg::PH_CRC2;
                        end
                        mrtu_pkg::PH_CRC2:
                        begin
                            good  = ({item.rx_byte, crc_lo} == crc_acc);
                            reply = good && (addr_hold != mrtu_pkg::BROADCAST_ADDR);
                            want.crc_good       = good;
                            want.respond        = reply;
                            want.frame_address  = addr_hold;
                            want.function_code  = func_hold;
                            want.request_data   = data_hold;
                            want.response_code  = reply
                                                  ? (func_hold | mrtu_pkg::EXCEPTION_FLAG)
                                                  : 8'h00;
                            want.exception_code = !reply ? mrtu_pkg::EX_NONE :
                                                  (func_hold == mrtu_pkg::FC_WRITE_REGISTER) ?
                                                  mrtu_pkg::EX_ILLEGAL_FUNCTION :
                                                  mrtu_pkg::EX_ILLEGAL_DATA_ADDRESS;
                            report_q.push_back(want);
                            rx_phase = mrtu_pkg::PH_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            pending <= report_q.size();
        end
    end

endmodule

>>> tb/sv/modbus_rtu_slave_request_receiver_test.sv
`timescale 1ns / 1ps

module modbus_rtu_slave_request_receiver_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 235;

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            item_valid   = 1'b0;
    mrtu_pkg::item_t item         = '0;
    logic            result_ready = 1'b0;
    logic            cfg_valid    = 1'b0;
    logic [7:0]      cfg_data     = '0;

    logic              item_ready;
    logic              result_valid;
    mrtu_pkg::result_t result;
    logic              cfg_ready;

    int failures;
    int pending;
    int reports_checked;

    int         items_sent    = 0;
    int         cycle_count   = 0;
    int         address_count = 0;
    logic       steady        = 1'b0;
    logic       hold_request  = 1'b0;
    logic [7:0] own_addr      = mrtu_pkg::SLAVE_ADDRESS_RESET;

    always #6 clk = ~clk;

    modbus_rtu_slave_request_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    modbus_rtu_slave_request_receiver_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .reports_checked (reports_checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d reports pending", $time, pending);
            $display("[modbus_rtu_slave_request_receiver] ERROR");
            $finish;
        end
    end

    // drain reports at random, with one long hold-off under load
    initial
    begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= steady || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic send(input logic is_tick, input logic [7:0] octet);
        while (!steady && $urandom_range(99) < 33)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= {is_tick, octet};
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic tick();
        send(mrtu_pkg::ITEM_TIMEOUT, 8'($urandom));
    endtask

    // address, function, four data bytes, CRC low then high; stop after cut bytes
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] code,
                              input logic [31:0] words, input logic [15:0] crc_flip,
                              input int cut);
        logic [7:0]  octet [8];
        logic [15:0] acc;
        octet[0] = addr;
        octet[1] = code;
        octet[2] = words[31:24];
        octet[3] = words[23:16];
        octet[4] = words[15:8];
        octet[5] = words[7:0];
        acc = mrtu_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++)
        begin
            acc = acc ^ {8'h00, octet[i]};
            for (int j = 0; j < 8; j++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ mrtu_pkg::CRC_POLY) : (acc >> 1);
            end
        end
        acc = acc ^ crc_flip;
        octet[6] = acc[7:0];
        octet[7] = acc[15:8];
        for (int i = 0; i < cut; i++)
        begin
            send(mrtu_pkg::ITEM_BYTE, octet[i]);
        end
    endtask

    task automatic drain();
        tick();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_slave_address(input logic [7:0] addr);
        drain();
        cfg_data  <= addr;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        own_addr = addr;
        address_count++;
    endtask

    task automatic run_traffic(input int quota);
        int         stop_at;
        int         pick;
        int         cut;
        logic [7:0] addr;
        logic [7:0] code;
        logic [15:0] flip;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            tick();
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send(($urandom_range(99) < 20) ? mrtu_pkg::ITEM_TIMEOUT
                                                   : mrtu_pkg::ITEM_BYTE,
                         8'($urandom));
                end
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    addr = own_addr;
                end
                else if (pick < 70)
                begin
                    addr = mrtu_pkg::BROADCAST_ADDR;
                end
                else
                begin
                    addr = 8'($urandom);
                end
                if ($urandom_range(99) < 85)
                begin
                    case ($urandom_range(3))
                        0: code = mrtu_pkg::FC_READ_COILS;
                        1: code = mrtu_pkg::FC_READ_HOLDING;
                        2: code = mrtu_pkg::FC_WRITE_COIL;
                        default: code = mrtu_pkg::FC_WRITE_REGISTER;
                    endcase
                end
                else
                begin
                    code = 8'($urandom);
                end
                cut  = ($urandom_range(99) < 10) ? $urandom_range(1, 7) : 8;
                flip = ($urandom_range(99) < 80) ? 16'h0000 : 16'($urandom_range(1, 65535));
                send_frame(addr, code, $urandom, flip, cut);
                if ($urandom_range(99) < 20)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send(mrtu_pkg::ITEM_BYTE, 8'($urandom));
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tick();
        send_frame(own_addr, mrtu_pkg::FC_WRITE_REGISTER, 32'h0000_0000, 16'h0000, 8);
        send(mrtu_pkg::ITEM_BYTE, 8'hFF);
        tick();
        send_frame(mrtu_pkg::BROADCAST_ADDR, mrtu_pkg::FC_READ_HOLDING, 32'hFFFF_FFFF,
                   16'h0000, 8);
        tick();
        send_frame(own_addr, mrtu_pkg::FC_READ_COILS, 32'h5AA5_C33C, 16'h8001, 8);
        tick();
        send(mrtu_pkg::ITEM_BYTE, 8'hF7);
        tick();
        send_frame(own_addr, 8'h00, 32'h7E00_0000, 16'h0000, 4);
        tick();
        send_frame(own_addr, mrtu_pkg::FC_WRITE_COIL, 32'h0102_0304, 16'h0000, 3);

        set_slave_address(8'd247);
        run_traffic(PHASE_ITEMS);
        set_slave_address(8'd1);
        hold_request <= 1'b1;
        run_traffic(PHASE_ITEMS);
        hold_request <= 1'b0;
        set_slave_address(8'($urandom_range(2, 246)));
        steady <= 1'b1;
        run_traffic(PHASE_ITEMS);
        steady <= 1'b0;
        set_slave_address(8'($urandom_range(2, 246)));
        run_traffic(PHASE_ITEMS);
        set_slave_address(8'($urandom_range(2, 246)));
        run_traffic(PHASE_ITEMS);
        set_slave_address(8'd247);
        run_traffic(PHASE_ITEMS);
        drain();

        $display("run covered %0d items and %0d checked frame reports over %0d slave addresses",
                 items_sent, reports_checked, address_count + 1);
        if (failures == 0 && pending == 0)
        begin
            $display("[modbus_rtu_slave_request_receiver] OK");
        end
        else
        begin
            $display("[modbus_rtu_slave_request_receiver] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mrtu_pkg.sv
hdl/mrtu_rx_fsm.sv
hdl/mrtu_out_reg.sv
hdl/modbus_rtu_slave_request_receiver.sv
hdl/mrtu_checker.sv
tb/sv/modbus_rtu_slave_request_receiver_checker.sv
tb/sv/modbus_rtu_slave_request_receiver_test.sv
